FILE: design/gdas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdas_pkg: shared types and constants for the date add/subtract block
// Sequencer states, status codes and the calendar helper functions.
// ----------------------------------------------------------------------------
package gdas_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned CountW = 16;
  localparam int unsigned R400W  = 9;
  // signed running day value: covers day + count and day - count
  localparam int unsigned DaccW  = CountW + 2;

  localparam logic [YearW-1:0]  YearMin = YearW'(1);
  localparam logic [YearW-1:0]  YearMax = YearW'(9999);
  localparam logic [YearW-1:0]  Cycle400 = YearW'(400);
  localparam logic [MonthW-1:0] MonthFirst = MonthW'(1);
  localparam logic [MonthW-1:0] MonthLast  = MonthW'(12);
  localparam logic [R400W-1:0]  R400Last   = R400W'(399);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_STEP,
    ST_DOY,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_DATE  = 2'd1,
    STAT_OUT_RANGE = 2'd2
  } status_e;

  // y % 4 comes from the year's low bits, y % 100 / y % 400 from r400 = y % 400
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [R400W-1:0] r400);
    is_leap = (y_lo == 2'd0) &&
              !(r400 == R400W'(100) || r400 == R400W'(200) || r400 == R400W'(300));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    case (m)
      4'd2:                     month_len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:  month_len = DayW'(30);
      default:                  month_len = DayW'(31);
    endcase
  endfunction

endpackage : gdas_pkg
`default_nettype wire

FILE: design/gregorian_date_add_subtract_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_add_subtract_top: Gregorian date plus/minus a day count
// Steps one month per cycle through a shared add/compare unit.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. After accept the block first
// reduces the year mod 400 (one subtract per cycle), checks the date (an
// invalid date goes straight to the output stage), then walks the date one
// month per cycle through a single adder and compare, then sums the month
// lengths for the day of year and loads the output register once it is free.
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register while the next transaction is taken.
// day_count above DAY_COUNT_MAX saturates to it.
module gregorian_date_add_subtract_top
  import gdas_pkg::*;
#(
  parameter int unsigned DAY_COUNT_MAX = 65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [13:0] year_in, [17:14] month_in, [22:18] day_in, [38:23] day_count, [39] zero
  input  wire logic [39:0] s_axis_tdata,
  // [0] action (0 add, 1 subtract)
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [13:0] year_out, [17:14] month_out, [22:18] day_out, [31:23] day_of_year
  output logic [31:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser
);

  state_e state_q, state_d;

  logic                       act_q, act_d;
  logic [YearW-1:0]           yin_q, yin_d;
  logic [MonthW-1:0]          min_q, min_d;
  logic [DayW-1:0]            din_q, din_d;
  logic [CountW-1:0]          cnt_q, cnt_d;
  logic [YearW-1:0]           red_q, red_d;
  logic [R400W-1:0]           r400in_q, r400in_d;
  logic [YearW-1:0]           y_q, y_d;
  logic [MonthW-1:0]          m_q, m_d;
  logic [R400W-1:0]           r400_q, r400_d;
  logic signed [DaccW-1:0]    dacc_q, dacc_d;
  logic [MonthW-1:0]          idx_q, idx_d;
  logic [DoyW-1:0]            doy_q, doy_d;
  status_e                    stat_q, stat_d;

  logic                       out_valid_q, out_valid_d;
  logic [31:0]                out_data_q, out_data_d;
  logic [1:0]                 out_user_q, out_user_d;

  logic [CountW-1:0]          cnt_sat;
  logic                       leap_cur;
  logic [DayW-1:0]            ml_cur;
  logic [MonthW-1:0]          m_prev;
  logic [YearW-1:0]           y_prev;
  logic [R400W-1:0]           r400_prev;
  logic                       wrap_back;
  logic [DayW-1:0]            ml_prev;
  logic signed [DaccW-1:0]    step_opnd;
  logic signed [DaccW-1:0]    dacc_sum;
  logic                       need_step;

  assign cnt_sat = (32'(s_axis_tdata[38:23]) > 32'(DAY_COUNT_MAX)) ?
                   CountW'(DAY_COUNT_MAX) : s_axis_tdata[38:23];

  assign leap_cur = is_leap(y_q[1:0], r400_q);
  assign ml_cur   = month_len(m_q, leap_cur);

  // previous month for the subtract walk
  assign wrap_back = (m_q == MonthFirst);
  assign m_prev    = wrap_back ? MonthLast : m_q - MonthW'(1);
  assign y_prev    = wrap_back ? y_q - YearW'(1) : y_q;
  assign r400_prev = !wrap_back ? r400_q :
                     (r400_q == '0) ? R400Last : r400_q - R400W'(1);
  assign ml_prev   = month_len(m_prev, is_leap(y_prev[1:0], r400_prev));

  // the shared adder
  assign step_opnd = act_q ? DaccW'(ml_prev) : -DaccW'(ml_cur);
  assign dacc_sum  = dacc_q + step_opnd;
  assign need_step = act_q ? (dacc_q < DaccW'(1)) : (dacc_q > DaccW'(ml_cur));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    yin_q      <= yin_d;
    min_q      <= min_d;
    din_q      <= din_d;
    cnt_q      <= cnt_d;
    red_q      <= red_d;
    r400in_q   <= r400in_d;
    y_q        <= y_d;
    m_q        <= m_d;
    r400_q     <= r400_d;
    dacc_q     <= dacc_d;
    idx_q      <= idx_d;
    doy_q      <= doy_d;
    stat_q     <= stat_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    yin_d       = yin_q;
    min_d       = min_q;
    din_d       = din_q;
    cnt_d       = cnt_q;
    red_d       = red_q;
    r400in_d    = r400in_q;
    y_d         = y_q;
    m_d         = m_q;
    r400_d      = r400_q;
    dacc_d      = dacc_q;
    idx_d       = idx_q;
    doy_d       = doy_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          act_d   = s_axis_tuser;
          yin_d   = s_axis_tdata[13:0];
          min_d   = s_axis_tdata[17:14];
          din_d   = s_axis_tdata[22:18];
          cnt_d   = cnt_sat;
          red_d   = s_axis_tdata[13:0];
          state_d = ST_MOD;
        end
      end

      ST_MOD: begin
        if (red_q >= Cycle400) begin
          red_d = red_q - Cycle400;
        end else begin
          r400in_d = red_q[R400W-1:0];
          r400_d   = red_q[R400W-1:0];
          state_d  = ST_CHECK;
        end
      end

      ST_CHECK: begin
        y_d = yin_q;
        m_d = min_q;
        if (yin_q < YearMin || yin_q > YearMax || min_q < MonthFirst ||
            min_q > MonthLast || din_q == '0 ||
            din_q > month_len(min_q, is_leap(yin_q[1:0], r400_q))) begin
          stat_d  = STAT_BAD_DATE;
          doy_d   = '0;
          state_d = ST_FINISH;
        end else begin
          stat_d  = STAT_OK;
          dacc_d  = act_q ? DaccW'(din_q) - DaccW'(cnt_q) : DaccW'(din_q) + DaccW'(cnt_q);
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        if (!need_step) begin
          doy_d   = DoyW'(dacc_q[DayW-1:0]);
          idx_d   = MonthFirst;
          state_d = ST_DOY;
        end else if (!act_q) begin
          if (m_q == MonthLast) begin
            if (y_q == YearMax) begin
              stat_d = STAT_OUT_RANGE;
            end else begin
              dacc_d = dacc_sum;
              m_d    = MonthFirst;
              y_d    = y_q + YearW'(1);
              r400_d = (r400_q == R400Last) ? '0 : r400_q + R400W'(1);
            end
          end else begin
            dacc_d = dacc_sum;
            m_d    = m_q + MonthW'(1);
          end
        end else begin
          if (wrap_back && y_q <= YearMin) begin
            stat_d = STAT_OUT_RANGE;
          end else begin
            dacc_d = dacc_sum;
            m_d    = m_prev;
            y_d    = y_prev;
            r400_d = r400_prev;
          end
        end
        if (stat_d == STAT_OUT_RANGE) begin
          // fall back to the input date and its day of year
          y_d     = yin_q;
          m_d     = min_q;
          r400_d  = r400in_q;
          doy_d   = DoyW'(din_q);
          idx_d   = MonthFirst;
          state_d = ST_DOY;
        end
      end

      ST_DOY: begin
        if (idx_q < m_q) begin
          doy_d = doy_q + DoyW'(month_len(idx_q, leap_cur));
          idx_d = idx_q + MonthW'(1);
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_user_d  = stat_q;
          if (stat_q == STAT_OK) begin
            out_data_d = {doy_q, dacc_q[DayW-1:0], m_q, y_q};
          end else begin
            out_data_d = {doy_q, din_q, min_q, yin_q};
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule : gregorian_date_add_subtract_top
`default_nettype wire
